@@ design/sssa_pkg.sv @@
// Shared constants, codes and types of the scoped stack slot allocator.
package sssa_pkg;

  localparam int MAX_SLOTS  = 64;
  localparam int MAX_LEVELS = 16;
  localparam int SLOT_AW    = $clog2(MAX_SLOTS);
  localparam int SLOT_CW    = $clog2(MAX_SLOTS + 1);
  localparam int LVL_AW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LVL_CW     = $clog2(MAX_LEVELS + 1);

  localparam int OFF_W  = 21;
  localparam int SIZE_W = 7;
  localparam int CNT_W  = 13;
  localparam int PROD_W = SIZE_W + CNT_W;
  localparam int BYTE_W = 19;
  localparam int WIDE_W = 24;
  localparam int MAG_W  = 23;

  localparam logic [2:0] FN_PUSH  = 3'd0;
  localparam logic [2:0] FN_FREE  = 3'd1;
  localparam logic [2:0] FN_LAST  = 3'd2;
  localparam logic [2:0] FN_OPEN  = 3'd3;
  localparam logic [2:0] FN_CLOSE = 3'd4;
  localparam logic [2:0] FN_FIND  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_NO_LEVEL  = 3'd5;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  cnt;
  } slot_t;

endpackage

@@ design/sssa_slot_ram.sv @@
// Slot table memory with one write port and one registered read port.
module sssa_slot_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [sssa_pkg::SLOT_AW-1:0] waddr_i,
  input  sssa_pkg::slot_t             wdata_i,
  input  logic [sssa_pkg::SLOT_AW-1:0] raddr_i,
  output sssa_pkg::slot_t             rdata_o
);

  sssa_pkg::slot_t mem [sssa_pkg::MAX_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/sssa_rem.sv @@
// Bit-serial remainder unit: magnitude modulo element size, one bit per cycle.
module sssa_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sssa_pkg::MAG_W-1:0]   dividend_i,
  input  logic [sssa_pkg::SIZE_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [sssa_pkg::SIZE_W-1:0]  rem_o
);

  logic [sssa_pkg::MAG_W-1:0]  quo_q;
  logic [sssa_pkg::SIZE_W:0]   rem_q;
  logic [sssa_pkg::SIZE_W-1:0] div_q;
  logic [4:0]                  cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [sssa_pkg::SIZE_W:0]   trial;
  logic [sssa_pkg::SIZE_W:0]   rem_d;

  always_comb begin
    trial = {rem_q[sssa_pkg::SIZE_W-1:0], quo_q[sssa_pkg::MAG_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = trial - {1'b0, div_q};
    end else begin
      rem_d = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(sssa_pkg::MAG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[sssa_pkg::MAG_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[sssa_pkg::SIZE_W-1:0];

endmodule

@@ design/scoped_stack_slot_allocator.sv @@
// Top level: sequencer of the scoped stack slot allocator.
// An operation is accepted when start_i is high and busy_o low; done_o pulses with the result.
// Open, close and unused codes finish directly from idle; free last reads the top slot and pops it.
// Find and free walk the table slot by slot; free then shifts the later slots down.
// Push walks the current level, aligning a fitting gap with the remainder unit, then shifts later slots up.
// Reset empties the table and leaves one level open; the result strobe cannot be stalled.
module scoped_stack_slot_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [2:0]                   func_i,
  input  logic [sssa_pkg::SIZE_W-1:0]  elem_size_i,
  input  logic [sssa_pkg::CNT_W-1:0]   elem_count_i,
  input  logic signed [sssa_pkg::OFF_W-1:0] slot_addr_i,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic signed [sssa_pkg::OFF_W-1:0] result_offset_o,
  output logic [sssa_pkg::BYTE_W-1:0]  result_bytes_o,
  output logic [sssa_pkg::SIZE_W-1:0]  result_elem_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NEED  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LAT   = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_DIVGO = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_SHCHK = 4'd7;
  localparam logic [3:0] S_SHWR  = 4'd8;

  localparam logic [2:0] PH_FRONT  = 3'd0;
  localparam logic [2:0] PH_PREV   = 3'd1;
  localparam logic [2:0] PH_NEXT   = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_SEARCH = 3'd4;
  localparam logic [2:0] PH_LAST   = 3'd5;

  localparam int SW = sssa_pkg::SLOT_CW;
  localparam int WW = sssa_pkg::WIDE_W;
  localparam logic signed [WW-1:0] FRAME_MIN = -WW'(1048576);
  localparam logic [sssa_pkg::PROD_W-1:0] BYTE_MAX = sssa_pkg::PROD_W'(524287);

  logic [3:0] st_q;
  logic [2:0] ph_q;
  logic [2:0] func_q;
  logic [sssa_pkg::SIZE_W-1:0] sz_q;
  logic [sssa_pkg::CNT_W-1:0]  cnt_q;
  logic [sssa_pkg::OFF_W-1:0]  addr_q;
  logic [sssa_pkg::PROD_W-1:0] need_q;
  logic [sssa_pkg::PROD_W-1:0] prod_q;
  sssa_pkg::slot_t             ent_q;
  sssa_pkg::slot_t             new_q;
  sssa_pkg::slot_t             rdata;
  logic [SW-1:0] idx_q, k_q, pos_q, tot_q;
  logic          shins_q, up_q;
  logic signed [WW-1:0] prev_q, val_q;
  logic [sssa_pkg::LVL_CW-1:0] lvt_q;
  logic [SW-1:0] lvl_q [sssa_pkg::MAX_LEVELS];

  logic        done_q;
  logic [2:0]  res_st_q;
  logic [sssa_pkg::OFF_W-1:0]  res_off_q;
  logic [sssa_pkg::BYTE_W-1:0] res_bytes_q;
  logic [sssa_pkg::SIZE_W-1:0] res_elem_q;

  logic [SW-1:0] cur, cnt_lvl;
  logic [sssa_pkg::SIZE_W-1:0] mul_a, eff_sz;
  logic [sssa_pkg::CNT_W-1:0]  mul_b;
  logic [sssa_pkg::PROD_W-1:0] mul_p;
  logic        we;
  logic [sssa_pkg::SLOT_AW-1:0] waddr, raddr;
  sssa_pkg::slot_t wdata;
  logic        div_done;
  logic [sssa_pkg::SIZE_W-1:0] rem;
  logic [sssa_pkg::MAG_W-1:0]  mag;
  logic signed [WW-1:0] ent_off, ent_top, need_w, rnd, eff_w, rem_w;

  function automatic logic [sssa_pkg::SIZE_W-1:0] eff(input logic [sssa_pkg::SIZE_W-1:0] s);
    eff = (s == '0) ? sssa_pkg::SIZE_W'(1) : s;
  endfunction

  function automatic logic [sssa_pkg::BYTE_W-1:0] sat(input logic [sssa_pkg::PROD_W-1:0] p);
    sat = (p > BYTE_MAX) ? sssa_pkg::BYTE_W'(BYTE_MAX) : p[sssa_pkg::BYTE_W-1:0];
  endfunction

  assign cur     = lvl_q[sssa_pkg::LVL_AW'(lvt_q - sssa_pkg::LVL_CW'(1))];
  assign cnt_lvl = tot_q - cur;
  assign eff_sz  = eff(sz_q);
  assign ent_off = WW'($signed(ent_q.off));
  assign ent_top = ent_off + $signed(WW'(prod_q));
  assign need_w  = $signed(WW'(need_q));
  assign eff_w   = $signed(WW'(eff_sz));
  assign rem_w   = $signed(WW'(rem));
  assign mag     = val_q[WW-1] ? sssa_pkg::MAG_W'(-val_q) : sssa_pkg::MAG_W'(val_q);

  always_comb begin
    if (st_q == S_NEED) begin
      mul_a = sz_q;
      mul_b = cnt_q;
    end else begin
      mul_a = rdata.size;
      mul_b = rdata.cnt;
    end
    mul_p = sssa_pkg::PROD_W'(eff(mul_a)) * sssa_pkg::PROD_W'(mul_b);
  end

  always_comb begin
    if (up_q) begin
      if (val_q < 0) begin
        rnd = val_q + rem_w;
      end else if (val_q > 0 && rem != '0) begin
        rnd = val_q + eff_w - rem_w;
      end else begin
        rnd = val_q;
      end
    end else begin
      if (val_q < 0 && rem != '0) begin
        rnd = val_q + rem_w - eff_w;
      end else if (val_q > 0) begin
        rnd = val_q - rem_w;
      end else begin
        rnd = val_q;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = k_q[sssa_pkg::SLOT_AW-1:0];
    wdata = rdata;
    raddr = idx_q[sssa_pkg::SLOT_AW-1:0];
    if (st_q == S_SHWR) begin
      we = 1'b1;
    end else if (st_q == S_SHCHK) begin
      if (shins_q) begin
        raddr = sssa_pkg::SLOT_AW'(k_q - SW'(1));
        if (k_q <= pos_q) begin
          we    = 1'b1;
          waddr = pos_q[sssa_pkg::SLOT_AW-1:0];
          wdata = new_q;
        end
      end else begin
        raddr = sssa_pkg::SLOT_AW'(k_q + SW'(1));
      end
    end
  end

  sssa_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sssa_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (st_q == S_DIVGO),
    .dividend_i (mag),
    .divisor_i  (eff_sz),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      tot_q   <= '0;
      lvt_q   <= sssa_pkg::LVL_CW'(1);
      done_q  <= 1'b0;
      for (int l = 0; l < sssa_pkg::MAX_LEVELS; l++) begin
        lvl_q[l] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (start_i) begin
            func_q      <= func_i;
            sz_q        <= elem_size_i;
            cnt_q       <= elem_count_i;
            addr_q      <= slot_addr_i;
            res_st_q    <= sssa_pkg::ST_OK;
            res_off_q   <= '0;
            res_bytes_q <= '0;
            res_elem_q  <= '0;
            idx_q       <= '0;
            case (func_i)
              sssa_pkg::FN_PUSH: begin
                if (tot_q >= SW'(sssa_pkg::MAX_SLOTS)) begin
                  res_st_q <= sssa_pkg::ST_FULL;
                  done_q   <= 1'b1;
                end else begin
                  st_q <= S_NEED;
                end
              end
              sssa_pkg::FN_FREE: begin
                if (tot_q == cur) begin
                  res_st_q <= sssa_pkg::ST_EMPTY;
                  done_q   <= 1'b1;
                end else begin
                  ph_q <= PH_SEARCH;
                  st_q <= S_RD;
                end
              end
              sssa_pkg::FN_LAST: begin
                if (tot_q == cur) begin
                  res_st_q <= sssa_pkg::ST_EMPTY;
                  done_q   <= 1'b1;
                end else begin
                  idx_q <= tot_q - SW'(1);
                  ph_q  <= PH_LAST;
                  st_q  <= S_RD;
                end
              end
              sssa_pkg::FN_OPEN: begin
                if (lvt_q >= sssa_pkg::LVL_CW'(sssa_pkg::MAX_LEVELS)) begin
                  res_st_q <= sssa_pkg::ST_FULL;
                end else begin
                  lvl_q[sssa_pkg::LVL_AW'(lvt_q)] <= tot_q;
                  lvt_q <= lvt_q + sssa_pkg::LVL_CW'(1);
                end
                done_q <= 1'b1;
              end
              sssa_pkg::FN_CLOSE: begin
                if (lvt_q <= sssa_pkg::LVL_CW'(1)) begin
                  res_st_q <= sssa_pkg::ST_NO_LEVEL;
                end else begin
                  tot_q <= cur;
                  lvt_q <= lvt_q - sssa_pkg::LVL_CW'(1);
                end
                done_q <= 1'b1;
              end
              sssa_pkg::FN_FIND: begin
                if (tot_q == '0) begin
                  res_st_q <= sssa_pkg::ST_NOT_FOUND;
                  done_q   <= 1'b1;
                end else begin
                  ph_q <= PH_SEARCH;
                  st_q <= S_RD;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_NEED: begin
          need_q <= mul_p;
          if (cnt_lvl == SW'(1) && lvt_q == sssa_pkg::LVL_CW'(1)) begin
            idx_q <= cur;
            ph_q  <= PH_FRONT;
            st_q  <= S_RD;
          end else if (cnt_lvl >= SW'(2)) begin
            idx_q <= cur;
            ph_q  <= PH_PREV;
            st_q  <= S_RD;
          end else if (tot_q != '0) begin
            idx_q <= tot_q - SW'(1);
            ph_q  <= PH_TAIL;
            st_q  <= S_RD;
          end else begin
            val_q <= -$signed(WW'(mul_p));
            up_q  <= 1'b0;
            st_q  <= S_DIVGO;
          end
        end
        S_RD: begin
          st_q <= S_LAT;
        end
        S_LAT: begin
          ent_q  <= rdata;
          prod_q <= mul_p;
          st_q   <= S_EVAL;
        end
        S_EVAL: begin
          case (ph_q)
            PH_FRONT: begin
              if (-ent_top >= need_w) begin
                pos_q       <= idx_q;
                k_q         <= tot_q;
                shins_q     <= 1'b1;
                new_q       <= '{off: sssa_pkg::OFF_W'(-need_w), size: sz_q, cnt: cnt_q};
                res_off_q   <= sssa_pkg::OFF_W'(-need_w);
                res_bytes_q <= sat(need_q);
                res_elem_q  <= sz_q;
                st_q        <= S_SHCHK;
              end else begin
                idx_q <= tot_q - SW'(1);
                ph_q  <= PH_TAIL;
                st_q  <= S_RD;
              end
            end
            PH_PREV: begin
              prev_q <= ent_off;
              idx_q  <= idx_q + SW'(1);
              ph_q   <= PH_NEXT;
              st_q   <= S_RD;
            end
            PH_NEXT: begin
              if (prev_q - ent_top >= need_w) begin
                val_q <= ent_top;
                up_q  <= 1'b1;
                st_q  <= S_DIVGO;
              end else if (idx_q + SW'(1) < tot_q) begin
                prev_q <= ent_off;
                idx_q  <= idx_q + SW'(1);
                st_q   <= S_RD;
              end else begin
                idx_q <= tot_q - SW'(1);
                ph_q  <= PH_TAIL;
                st_q  <= S_RD;
              end
            end
            PH_TAIL: begin
              val_q <= ent_off - need_w;
              up_q  <= 1'b0;
              st_q  <= S_DIVGO;
            end
            PH_SEARCH: begin
              if (ent_q.off == addr_q) begin
                res_off_q   <= ent_q.off;
                res_bytes_q <= sat(prod_q);
                res_elem_q  <= ent_q.size;
                if (func_q == sssa_pkg::FN_FIND) begin
                  done_q <= 1'b1;
                  st_q   <= S_IDLE;
                end else begin
                  pos_q   <= idx_q;
                  k_q     <= idx_q;
                  shins_q <= 1'b0;
                  st_q    <= S_SHCHK;
                end
              end else if (idx_q + SW'(1) < tot_q) begin
                idx_q <= idx_q + SW'(1);
                st_q  <= S_RD;
              end else begin
                res_st_q <= sssa_pkg::ST_NOT_FOUND;
                done_q   <= 1'b1;
                st_q     <= S_IDLE;
              end
            end
            PH_LAST: begin
              res_off_q   <= ent_q.off;
              res_bytes_q <= sat(prod_q);
              res_elem_q  <= ent_q.size;
              tot_q       <= tot_q - SW'(1);
              done_q      <= 1'b1;
              st_q        <= S_IDLE;
            end
            default: begin
              st_q <= S_IDLE;
            end
          endcase
        end
        S_DIVGO: begin
          st_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (up_q) begin
              if (prev_q - rnd >= need_w) begin
                pos_q       <= idx_q;
                k_q         <= tot_q;
                shins_q     <= 1'b1;
                new_q       <= '{off: sssa_pkg::OFF_W'(rnd), size: sz_q, cnt: cnt_q};
                res_off_q   <= sssa_pkg::OFF_W'(rnd);
                res_bytes_q <= sat(need_q);
                res_elem_q  <= sz_q;
                st_q        <= S_SHCHK;
              end else if (idx_q + SW'(1) < tot_q) begin
                prev_q <= ent_off;
                idx_q  <= idx_q + SW'(1);
                ph_q   <= PH_NEXT;
                st_q   <= S_RD;
              end else begin
                idx_q <= tot_q - SW'(1);
                ph_q  <= PH_TAIL;
                st_q  <= S_RD;
              end
            end else if (rnd < FRAME_MIN) begin
              res_st_q <= sssa_pkg::ST_OVERFLOW;
              done_q   <= 1'b1;
              st_q     <= S_IDLE;
            end else begin
              pos_q       <= tot_q;
              k_q         <= tot_q;
              shins_q     <= 1'b1;
              new_q       <= '{off: sssa_pkg::OFF_W'(rnd), size: sz_q, cnt: cnt_q};
              res_off_q   <= sssa_pkg::OFF_W'(rnd);
              res_bytes_q <= sat(need_q);
              res_elem_q  <= sz_q;
              st_q        <= S_SHCHK;
            end
          end
        end
        S_SHCHK: begin
          if (shins_q) begin
            if (k_q > pos_q) begin
              st_q <= S_SHWR;
            end else begin
              tot_q  <= tot_q + SW'(1);
              done_q <= 1'b1;
              st_q   <= S_IDLE;
            end
          end else begin
            if (k_q + SW'(1) < tot_q) begin
              st_q <= S_SHWR;
            end else begin
              tot_q <= tot_q - SW'(1);
              for (int l = 1; l < sssa_pkg::MAX_LEVELS; l++) begin
                if (sssa_pkg::LVL_CW'(l) < lvt_q && lvl_q[l] > pos_q) begin
                  lvl_q[l] <= lvl_q[l] - SW'(1);
                end
              end
              done_q <= 1'b1;
              st_q   <= S_IDLE;
            end
          end
        end
        S_SHWR: begin
          k_q  <= shins_q ? k_q - SW'(1) : k_q + SW'(1);
          st_q <= S_SHCHK;
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (st_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = res_st_q;
  assign result_offset_o = res_off_q;
  assign result_bytes_o  = res_bytes_q;
  assign result_elem_o   = res_elem_q;

endmodule

@@ bench/scoped_stack_slot_allocator_tb.sv @@
// Self-checking testbench of the scoped stack slot allocator with a built-in slot table predictor.
`timescale 1ns / 1ps

module scoped_stack_slot_allocator_tb;

  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM    = 550;

  typedef struct {
    logic [2:0]                  func;
    logic [sssa_pkg::SIZE_W-1:0] size;
    logic [sssa_pkg::CNT_W-1:0]  cnt;
    logic [sssa_pkg::OFF_W-1:0]  addr;
  } op_t;

  typedef struct {
    logic [2:0]                  status;
    logic [sssa_pkg::OFF_W-1:0]  off;
    logic [sssa_pkg::BYTE_W-1:0] bytes;
    logic [sssa_pkg::SIZE_W-1:0] elem;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [2:0] func_i = '0;
  logic [sssa_pkg::SIZE_W-1:0] elem_size_i = '0;
  logic [sssa_pkg::CNT_W-1:0] elem_count_i = '0;
  logic signed [sssa_pkg::OFF_W-1:0] slot_addr_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic signed [sssa_pkg::OFF_W-1:0] result_offset_o;
  logic [sssa_pkg::BYTE_W-1:0] result_bytes_o;
  logic [sssa_pkg::SIZE_W-1:0] result_elem_o;

  scoped_stack_slot_allocator DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the frame table and the start index of each level.
  longint tbl_off[sssa_pkg::MAX_SLOTS];
  int     tbl_size[sssa_pkg::MAX_SLOTS];
  int     tbl_cnt[sssa_pkg::MAX_SLOTS];
  int     lvl_base[sssa_pkg::MAX_LEVELS];
  int     n_slots = 0;
  int     n_levels = 1;

  op_t    pending_ops[$];
  res_t   expected_results[$];
  int     errors = 0;
  bit     stim_done = 0;
  bit     hold_off = 0;

  function automatic void queue_op(op_t o);
    pending_ops.insert(pending_ops.size(), o);
  endfunction

  function automatic longint esz(int s);
    return (s == 0) ? 1 : s;
  endfunction

  function automatic longint span(int i);
    return esz(tbl_size[i]) * tbl_cnt[i];
  endfunction

  function automatic res_t slot_res(logic [2:0] st, int i);
    res_t r;
    longint b;
    b = span(i);
    if (b > 524287) b = 524287;
    r.status = st;
    r.off = tbl_off[i][sssa_pkg::OFF_W-1:0];
    r.bytes = b[sssa_pkg::BYTE_W-1:0];
    r.elem = tbl_size[i][sssa_pkg::SIZE_W-1:0];
    return r;
  endfunction

  function automatic res_t bare_res(logic [2:0] st);
    res_t r;
    r.status = st;
    r.off = '0;
    r.bytes = '0;
    r.elem = '0;
    return r;
  endfunction

  function automatic int put_slot(int pos, longint off, int sz, int cnt);
    for (int k = n_slots; k > pos; k--) begin
      tbl_off[k] = tbl_off[k-1];
      tbl_size[k] = tbl_size[k-1];
      tbl_cnt[k] = tbl_cnt[k-1];
    end
    tbl_off[pos] = off;
    tbl_size[pos] = sz;
    tbl_cnt[pos] = cnt;
    n_slots++;
    return pos;
  endfunction

  function automatic longint ceil_to(longint v, longint a);
    longint q;
    q = v / a;
    if (v % a != 0 && v > 0) q++;
    return q * a;
  endfunction

  function automatic longint floor_to(longint v, longint a);
    longint q;
    q = v / a;
    if (v % a != 0 && v < 0) q--;
    return q * a;
  endfunction

  function automatic res_t place_slot(int sz, int cnt);
    longint a, need, off, nxt, prv, al;
    int s, c;
    a = esz(sz);
    need = a * cnt;
    s = lvl_base[n_levels-1];
    c = n_slots - s;
    if (n_slots >= sssa_pkg::MAX_SLOTS) return bare_res(sssa_pkg::ST_FULL);
    if (c == 1 && n_levels == 1) begin
      if (-(tbl_off[s] + span(s)) >= need)
        return slot_res(sssa_pkg::ST_OK, put_slot(s, -need, sz, cnt));
    end
    for (int n = 0; n + 1 < c; n++) begin
      nxt = tbl_off[s+n+1] + span(s+n+1);
      prv = tbl_off[s+n];
      if (prv - nxt >= need) begin
        al = ceil_to(nxt, a);
        if (prv - al >= need)
          return slot_res(sssa_pkg::ST_OK, put_slot(s+n+1, al, sz, cnt));
      end
    end
    off = (n_slots > 0) ? tbl_off[n_slots-1] - need : -need;
    off = floor_to(off, a);
    if (off < -1048576) return bare_res(sssa_pkg::ST_OVERFLOW);
    return slot_res(sssa_pkg::ST_OK, put_slot(n_slots, off, sz, cnt));
  endfunction

  function automatic int lookup(longint addr);
    for (int i = 0; i < n_slots; i++) if (tbl_off[i] == addr) return i;
    return -1;
  endfunction

  function automatic res_t predict_op(op_t op);
    res_t r;
    int cur, i;
    longint addr;
    cur = lvl_base[n_levels-1];
    addr = longint'(signed'(op.addr));
    case (op.func)
      sssa_pkg::FN_PUSH: r = place_slot(op.size, op.cnt);
      sssa_pkg::FN_FREE: begin
        if (n_slots == cur) return bare_res(sssa_pkg::ST_EMPTY);
        i = lookup(addr);
        if (i < 0) return bare_res(sssa_pkg::ST_NOT_FOUND);
        r = slot_res(sssa_pkg::ST_OK, i);
        for (int k = i; k + 1 < n_slots; k++) begin
          tbl_off[k] = tbl_off[k+1];
          tbl_size[k] = tbl_size[k+1];
          tbl_cnt[k] = tbl_cnt[k+1];
        end
        n_slots--;
        for (int l = 1; l < n_levels; l++) if (lvl_base[l] > i) lvl_base[l]--;
      end
      sssa_pkg::FN_LAST: begin
        if (n_slots == cur) return bare_res(sssa_pkg::ST_EMPTY);
        r = slot_res(sssa_pkg::ST_OK, n_slots - 1);
        n_slots--;
      end
      sssa_pkg::FN_OPEN: begin
        if (n_levels >= sssa_pkg::MAX_LEVELS) return bare_res(sssa_pkg::ST_FULL);
        lvl_base[n_levels] = n_slots;
        n_levels++;
        r = bare_res(sssa_pkg::ST_OK);
      end
      sssa_pkg::FN_CLOSE: begin
        if (n_levels <= 1) return bare_res(sssa_pkg::ST_NO_LEVEL);
        n_slots = cur;
        n_levels--;
        r = bare_res(sssa_pkg::ST_OK);
      end
      sssa_pkg::FN_FIND: begin
        i = lookup(addr);
        r = (i < 0) ? bare_res(sssa_pkg::ST_NOT_FOUND) : slot_res(sssa_pkg::ST_OK, i);
      end
      default: r = bare_res(sssa_pkg::ST_OK);
    endcase
    return r;
  endfunction

  function automatic op_t mk(logic [2:0] f, int sz, int cnt, int addr);
    op_t o;
    o.func = f;
    o.size = sz[sssa_pkg::SIZE_W-1:0];
    o.cnt = cnt[sssa_pkg::CNT_W-1:0];
    o.addr = addr[sssa_pkg::OFF_W-1:0];
    return o;
  endfunction

  // Random operation; sizes mostly small, addresses often taken from the mirrored table.
  function automatic op_t rand_op();
    int r, sz, cnt, addr;
    r = $urandom_range(99);
    sz = ($urandom_range(9) == 0) ? $urandom_range(127) : (1 << $urandom_range(6));
    if ($urandom_range(4) == 0) sz = $urandom_range(64);
    cnt = ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(1, 16);
    if (n_slots > 0 && $urandom_range(3) != 0)
      addr = int'(tbl_off[$urandom_range(n_slots - 1)]);
    else
      addr = $urandom;
    if (r < 40) return mk(sssa_pkg::FN_PUSH, sz, cnt, $urandom);
    if (r < 55) return mk(sssa_pkg::FN_FREE, $urandom, $urandom, addr);
    if (r < 65) return mk(sssa_pkg::FN_LAST, $urandom, $urandom, $urandom);
    if (r < 74) return mk(sssa_pkg::FN_OPEN, $urandom, $urandom, $urandom);
    if (r < 82) return mk(sssa_pkg::FN_CLOSE, $urandom, $urandom, $urandom);
    if (r < 97) return mk(sssa_pkg::FN_FIND, $urandom, $urandom, addr);
    return mk(3'(6 + $urandom_range(1)), $urandom, $urandom, $urandom);
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  int gap_left = 0;
  int burst_left = 0;
  op_t cur_op;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.insert(expected_results.size(), predict_op(cur_op));
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (hold_off && expected_results.size() + (start_i ? 1 : 0) > 0) begin
        start_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        func_i <= cur_op.func;
        elem_size_i <= cur_op.size;
        elem_count_i <= cur_op.cnt;
        slot_addr_i <= cur_op.addr;
        start_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(20);
          gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  res_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          errors++;
        end
        if (result_offset_o !== exp_r.off) begin
          $error("result_offset: expected %0d, actual %0d",
                 signed'(exp_r.off), result_offset_o);
          errors++;
        end
        if (result_bytes_o !== exp_r.bytes) begin
          $error("result_bytes: expected %0d, actual %0d", exp_r.bytes, result_bytes_o);
          errors++;
        end
        if (result_elem_o !== exp_r.elem) begin
          $error("result_elem: expected %0d, actual %0d", exp_r.elem, result_elem_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else if (!stim_done) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int waited;
    // Release reset, then run the directed corner cases before the random phase.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_op(mk(sssa_pkg::FN_LAST, 0, 0, 0));
    queue_op(mk(sssa_pkg::FN_FREE, 0, 0, 0));
    queue_op(mk(sssa_pkg::FN_CLOSE, 0, 0, 0));
    queue_op(mk(sssa_pkg::FN_PUSH, 8, 4, 0));
    queue_op(mk(sssa_pkg::FN_PUSH, 0, 1, 0));
    queue_op(mk(sssa_pkg::FN_PUSH, 64, 8191, 0));
    queue_op(mk(sssa_pkg::FN_PUSH, 127, 8191, 0));
    queue_op(mk(sssa_pkg::FN_FIND, 0, 0, -32));
    queue_op(mk(sssa_pkg::FN_FIND, 0, 0, -1048576));
    queue_op(mk(sssa_pkg::FN_FIND, 0, 0, 1048575));
    queue_op(mk(sssa_pkg::FN_FREE, 0, 0, -32));
    queue_op(mk(sssa_pkg::FN_PUSH, 1, 1, 0));
    queue_op(mk(sssa_pkg::FN_FREE, 0, 0, 12345));
    queue_op(mk(sssa_pkg::FN_OPEN, 0, 0, 0));
    queue_op(mk(sssa_pkg::FN_PUSH, 4, 2, 0));
    queue_op(mk(sssa_pkg::FN_LAST, 0, 0, 0));
    queue_op(mk(3'd6, 127, 8191, -1));
    queue_op(mk(3'd7, 0, 0, 0));
    for (int k = 0; k < 16; k++) queue_op(mk(sssa_pkg::FN_OPEN, 0, 0, 0));
    for (int k = 0; k < 17; k++) queue_op(mk(sssa_pkg::FN_CLOSE, 0, 0, 0));
    while (pending_ops.size() > 0 || start_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    // Random phase: addresses come from the predictor's mirror of the table so they often hit existing slots.
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 2) begin
        while (pending_ops.size() > 0 || start_i) @(posedge clk_i);
        hold_off = 1;
        while (expected_results.size() > 0) @(posedge clk_i);
        hold_off = 0;
      end
      queue_op(rand_op());
      if (k % 70 < 30) for (int j = 0; j < 4; j++) queue_op(mk(sssa_pkg::FN_PUSH,
          1 << $urandom_range(6), $urandom_range(1, 40), 0));
      while (pending_ops.size() > 4) @(posedge clk_i);
    end
    while (pending_ops.size() > 0 || start_i) @(posedge clk_i);
    waited = 0;
    while (expected_results.size() > 0 && waited < STALL_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    stim_done = 1;
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
